/* rtl/frsa_pkg.sv */
// Package: command and status codes, payload structs and sequencer states.
package frsa_pkg;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_SUBMIT  = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_LOOKUP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BOUND     = 3'd1,
    ST_ZERO      = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  localparam logic [1:0] CFG_RING_SIZE  = 2'd0;
  localparam logic [1:0] CFG_ALIGN_LOG2 = 2'd1;
  localparam logic [3:0] ALIGN_MAX      = 4'd12;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] alloc_id;
    logic [31:0] alloc_gen;
    logic [32:0] alloc_size;
    logic [47:0] fence_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [32:0] offset;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RETIRE,
    S_FIND,
    S_PLACE,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

/* rtl/fenced_ring_span_allocator_unit.sv */
// Top level: fenced ring span allocator with a sequenced span-table scan.
// Sequence per command (N = MAX_SPANS): submit and release run a retire pass, lookup
//   a find pass that stops at a hit, and reserve a retire pass and a find pass, then
//   up to N placement passes unless the find pass rejects it.
// Throughput: one command at a time; the next beat is taken only after the result
//   is loaded into the output register.
// Reset: rst_n synchronous, active low; clears valid and fenced bits, sequencer,
//   result flag and configuration (ring_size 65536, align_log2 0); span payload is kept.
module fenced_ring_span_allocator_unit import frsa_pkg::*; #(
  parameter int MAX_SPANS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_wdata
);

  localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;

  // span table
  logic [MAX_SPANS-1:0] valid_r, fenced_r;
  logic [32:0] beg_r [MAX_SPANS];
  logic [32:0] end_r [MAX_SPANS];
  logic [31:0] id_r  [MAX_SPANS];
  logic [31:0] gen_r [MAX_SPANS];
  logic [47:0] fen_r [MAX_SPANS];

  logic [32:0] ring_size_r;
  logic [3:0]  align_r;

  state_t    state_r, state_nxt;
  in_beat_t  req_r;
  out_beat_t res_r;        // result being built
  out_beat_t out_data_r;   // result beat on the output channel
  logic      out_valid_r;

  logic [IW-1:0] idx_r;    // scan pointer, one span per cycle
  logic [IW-1:0] slot_r;   // lowest free slot
  logic          slot_ok_r;

  // placement walks the spans in begin order, one distinct begin per pass:
  // gap = highest end of spans already walked, lb = last begin walked,
  // fb/fe = lowest begin above lb and the highest end among spans at that begin
  logic [32:0] gap_r, lb_r, fb_r, fe_r;
  logic        seen_r, found_r;

  logic        last, hit, elig, fits;
  logic [3:0]  lg;
  logic [32:0] amask;
  logic [33:0] cand;
  logic [34:0] cand_end;

  assign last = (idx_r == IW'(MAX_SPANS - 1));
  assign hit  = valid_r[idx_r] && (id_r[idx_r] == req_r.alloc_id) &&
                (gen_r[idx_r] == req_r.alloc_gen);
  assign elig = valid_r[idx_r] && (!seen_r || beg_r[idx_r] > lb_r);

  // alignment saturates at 4 KiB; candidate start is the gap rounded up
  assign lg       = (align_r > ALIGN_MAX) ? ALIGN_MAX : align_r;
  assign amask    = (33'd1 << lg) - 33'd1;
  assign cand     = (34'(gap_r) + 34'(amask)) & ~34'(amask);
  assign cand_end = 35'(cand) + 35'(req_r.alloc_size);
  // hole below the next span (or up to ring end when none is left)
  assign fits     = (cand_end <= 35'(ring_size_r)) &&
                    (!found_r || cand_end <= 35'(fb_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (cmd_t'(in_data.cmd) == CMD_LOOKUP) state_nxt = S_FIND;
          else state_nxt = S_RETIRE;
        end
      end
      S_RETIRE: begin
        if (last) state_nxt = (cmd_t'(req_r.cmd) == CMD_RESERVE) ? S_FIND : S_DONE;
      end
      S_FIND: begin
        if (hit || last) begin
          if (hit || cmd_t'(req_r.cmd) == CMD_LOOKUP || req_r.alloc_size == 33'd0 ||
              (!slot_ok_r && valid_r[idx_r])) state_nxt = S_DONE;
          else state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        if (last) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        // no fit below the next span: walk past it and scan again
        state_nxt = (!fits && found_r) ? S_PLACE : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == S_IDLE);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      fenced_r    <= '0;
      ring_size_r <= 33'd65536;
      align_r     <= 4'd0;
      idx_r       <= '0;
      slot_ok_r   <= 1'b0;
      seen_r      <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CFG_RING_SIZE)  ring_size_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_ALIGN_LOG2) align_r <= cfg_wdata[3:0];
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r        <= in_data;
            idx_r        <= '0;
            slot_ok_r    <= 1'b0;
            res_r.status <= ST_OK;
            res_r.offset <= 33'd0;
          end
        end
        S_RETIRE: begin
          // submit fences open spans; reserve and release drop completed ones
          if (cmd_t'(req_r.cmd) == CMD_SUBMIT) begin
            if (valid_r[idx_r] && !fenced_r[idx_r]) begin
              fenced_r[idx_r] <= 1'b1;
              fen_r[idx_r]    <= req_r.fence_value;
            end
          end else if (valid_r[idx_r] && fenced_r[idx_r] &&
                       fen_r[idx_r] <= req_r.fence_value) begin
            valid_r[idx_r]  <= 1'b0;
            fenced_r[idx_r] <= 1'b0;
          end
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_FIND: begin
          if (!valid_r[idx_r] && !slot_ok_r) begin
            slot_ok_r <= 1'b1;
            slot_r    <= idx_r;
          end
          if (hit) begin
            if (cmd_t'(req_r.cmd) == CMD_LOOKUP) res_r.offset <= beg_r[idx_r];
            else res_r.status <= ST_BOUND;
          end else if (last) begin
            if (cmd_t'(req_r.cmd) == CMD_LOOKUP) res_r.status <= ST_NOT_FOUND;
            else if (req_r.alloc_size == 33'd0) res_r.status <= ST_ZERO;
            else if (!slot_ok_r && valid_r[idx_r]) res_r.status <= ST_EXHAUSTED;
          end
          idx_r   <= (hit || last) ? '0 : idx_r + 1'b1;
          gap_r   <= 33'd0;
          seen_r  <= 1'b0;
          found_r <= 1'b0;
        end
        S_PLACE: begin
          if (elig) begin
            if (!found_r || beg_r[idx_r] < fb_r) begin
              found_r <= 1'b1;
              fb_r    <= beg_r[idx_r];
              fe_r    <= end_r[idx_r];
            end else if (beg_r[idx_r] == fb_r && end_r[idx_r] > fe_r) begin
              fe_r <= end_r[idx_r];
            end
          end
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_WRITE: begin
          if (fits) begin
            valid_r[slot_r]  <= 1'b1;
            fenced_r[slot_r] <= 1'b0;
            beg_r[slot_r]    <= cand[32:0];
            end_r[slot_r]    <= cand_end[32:0];
            id_r[slot_r]     <= req_r.alloc_id;
            gen_r[slot_r]    <= req_r.alloc_gen;
            fen_r[slot_r]    <= 48'd0;
            res_r.offset     <= cand[32:0];
          end else if (found_r) begin
            if (fe_r > gap_r) gap_r <= fe_r;
            lb_r    <= fb_r;
            seen_r  <= 1'b1;
            found_r <= 1'b0;
          end else begin
            res_r.status <= ST_EXHAUSTED;
          end
        end
        default: ;
      endcase
    end
  end

  // output register: a held beat stalls the sequencer in S_DONE until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_DONE) else $error("stray result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat dropped or changed while stalled");
  a_fenced_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((fenced_r & ~valid_r) == '0)) else $error("fenced w/o valid");

endmodule

/* bench/fenced_ring_span_allocator_unit_tb.sv */
// Testbench for the fenced ring span allocator: random and directed commands checked by a span-table predictor.
`timescale 1ns / 100ps

module fenced_ring_span_allocator_unit_tb;
  import frsa_pkg::*;

  localparam int NSPAN = 16;

  // Span-table predictor plus a queue of expected result beats.
  class span_scoreboard;
    logic [32:0] ring_bytes;
    logic [3:0]  align_sel;
    bit          live[NSPAN];
    logic [32:0] lo_addr[NSPAN];
    logic [32:0] hi_addr[NSPAN];
    logic [31:0] owner_id[NSPAN];
    logic [31:0] owner_gen[NSPAN];
    bit          fence_set[NSPAN];
    logic [47:0] fence_at[NSPAN];
    out_beat_t   pending[$];
    int          errors;
    int          checked;
    int          n_ok;
    int          n_exhausted;

    function void clear();
      ring_bytes = 33'd65536;
      align_sel = 4'd0;
      foreach (live[i]) begin
        live[i] = 0;
        fence_set[i] = 0;
      end
      errors = 0;
      checked = 0;
      n_ok = 0;
      n_exhausted = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [32:0] val);
      if (idx == CFG_RING_SIZE) ring_bytes = val;
      else if (idx == CFG_ALIGN_LOG2) align_sel = val[3:0];
    endfunction

    function void retire(logic [47:0] done);
      foreach (live[i])
        if (live[i] && fence_set[i] && fence_at[i] <= done) begin
          live[i] = 0;
          fence_set[i] = 0;
        end
    endfunction

    function int find(logic [31:0] id, logic [31:0] gen);
      foreach (live[i])
        if (live[i] && owner_id[i] == id && owner_gen[i] == gen) return i;
      return -1;
    endfunction

    // First-fit over spans sorted by begin; sums kept at 64 bits so nothing wraps.
    function bit fit(logic [32:0] size, output logic [32:0] where);
      longint unsigned lo[$], hi[$];
      longint unsigned gap, a, msk, tl, th;
      int lg, j;
      gap = 0;
      lg = (align_sel > 12) ? 12 : align_sel;
      msk = (64'd1 << lg) - 1;
      foreach (live[i])
        if (live[i]) begin
          lo.insert(lo.size(), lo_addr[i]);
          hi.insert(hi.size(), hi_addr[i]);
          j = lo.size() - 1;
          while (j > 0 && (lo[j-1] > lo[j] || (lo[j-1] == lo[j] && hi[j-1] > hi[j]))) begin
            tl = lo[j]; th = hi[j];
            lo[j] = lo[j-1]; hi[j] = hi[j-1];
            lo[j-1] = tl; hi[j-1] = th;
            j--;
          end
        end
      foreach (lo[i]) begin
        a = (gap + msk) & ~msk;
        if (a + size <= lo[i] && a + size <= ring_bytes) begin
          where = a[32:0];
          return 1;
        end
        if (hi[i] > gap) gap = hi[i];
      end
      a = (gap + msk) & ~msk;
      where = a[32:0];
      return a + size <= ring_bytes;
    endfunction

    // Applies one accepted command and queues the beat it must produce.
    function void note_command(in_beat_t b);
      out_beat_t r;
      int slot;
      logic [32:0] where;
      r.status = ST_OK;
      r.offset = '0;
      case (cmd_t'(b.cmd))
        CMD_RESERVE: begin
          retire(b.fence_value);
          slot = -1;
          if (find(b.alloc_id, b.alloc_gen) >= 0) r.status = ST_BOUND;
          else if (b.alloc_size == 0) r.status = ST_ZERO;
          else begin
            foreach (live[i])
              if (!live[i] && slot < 0) slot = i;
            if (slot < 0 || !fit(b.alloc_size, where)) r.status = ST_EXHAUSTED;
            else begin
              live[slot] = 1;
              lo_addr[slot] = where;
              hi_addr[slot] = where + b.alloc_size;
              owner_id[slot] = b.alloc_id;
              owner_gen[slot] = b.alloc_gen;
              fence_set[slot] = 0;
              fence_at[slot] = '0;
              r.offset = where;
            end
          end
        end
        CMD_SUBMIT:
          foreach (live[i])
            if (live[i] && !fence_set[i]) begin
              fence_set[i] = 1;
              fence_at[i] = b.fence_value;
            end
        CMD_RELEASE: retire(b.fence_value);
        default: begin
          slot = find(b.alloc_id, b.alloc_gen);
          if (slot < 0) r.status = ST_NOT_FOUND;
          else r.offset = lo_addr[slot];
        end
      endcase
      if (r.status == ST_OK && b.cmd == CMD_RESERVE) n_ok++;
      if (r.status == ST_EXHAUSTED) n_exhausted++;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: status %0d offset %0h",
               got.status, got.offset);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.offset !== want.offset) begin
        $error("offset: expected %0h, got %0h", want.offset, got.offset);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_beat_t   out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [32:0] cfg_wdata = '0;

  span_scoreboard sb;
  int send_idle_pct = 0;   // chance, in percent, of a bubble before a beat
  int recv_stall_pct = 0;  // chance of out_ready low in a cycle
  int sent;

  // Small id space so duplicates and lookup hits are common.
  logic [31:0] id_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
  logic [47:0] fence_now;  // submitted fences climb so releases retire in order

  always #4 clk = ~clk;

  fenced_ring_span_allocator_unit dut (.*);

  // Receiver: random stalls, every beat checked at the rising edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  // Drives valid, after any random bubbles, from a falling edge until the beat is taken.
  task automatic send(in_beat_t b);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(b);
    sent++;
  endtask

  task automatic cmd(cmd_t c, logic [31:0] id, logic [31:0] gen, logic [32:0] sz,
                     logic [47:0] fv);
    in_beat_t b;
    b.cmd = c;
    b.alloc_id = id;
    b.alloc_gen = gen;
    b.alloc_size = sz;
    b.fence_value = fv;
    send(b);
  endtask

  // Drains the pipe, then lets the block settle before a register write.
  task automatic write_reg(logic [1:0] idx, logic [32:0] val);
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [32:0] rand_size();
    case ($urandom_range(9))
      0: return 33'd0;
      1: return 33'h1_0000_0000;
      2: return {1'b0, $urandom()};
      3: return {1'($urandom_range(1)), $urandom()};
      default: return 33'($urandom_range(1, 6000));
    endcase
  endfunction

  task automatic random_beat();
    int k;
    logic [47:0] fv;
    k = $urandom_range(99);
    fv = 48'({$urandom(), $urandom()});
    if (k < 50) begin
      // mostly completed fences near the live ones, sometimes wild
      if ($urandom_range(3) != 0) fv = fence_now - 48'($urandom_range(3));
      cmd(CMD_RESERVE, id_pool[$urandom_range(3)], $urandom_range(7), rand_size(), fv);
    end else if (k < 65) begin
      fence_now = fence_now + 48'($urandom_range(1, 3));
      cmd(CMD_SUBMIT, $urandom(), $urandom(), rand_size(),
          ($urandom_range(9) == 0) ? fv : fence_now);
    end else if (k < 75) begin
      cmd(CMD_RELEASE, $urandom(), $urandom(), rand_size(),
          ($urandom_range(2) == 0) ? fv : fence_now - 48'($urandom_range(2)));
    end else begin
      cmd(CMD_LOOKUP, ($urandom_range(4) == 0) ? $urandom() : id_pool[$urandom_range(3)],
          $urandom_range(7), rand_size(), fv);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sent = 0;
    fence_now = 48'd100;
    repeat (3) @(negedge clk);
    rst_n <= 1;

    // Directed: each command, zero size, duplicate, lookup miss, full table,
    // field extremes, alignment saturation.
    cmd(CMD_RESERVE, 32'h0, 32'h0, 33'd0, 48'd0);
    cmd(CMD_RESERVE, 32'h0, 32'h0, 33'd100, 48'd0);
    cmd(CMD_RESERVE, 32'h0, 32'h0, 33'd5, 48'd0);
    cmd(CMD_LOOKUP, 32'h0, 32'h0, 33'd0, '1);
    cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
    cmd(CMD_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_0000_0000, 48'd0);
    for (int i = 1; i <= 16; i++) cmd(CMD_RESERVE, i, 32'd9, 33'd16, 48'd0);
    cmd(CMD_SUBMIT, '0, '0, '0, 48'd50);
    cmd(CMD_RELEASE, '1, '1, '1, 48'd49);
    cmd(CMD_RESERVE, 32'd99, 32'd1, 33'd1, '1);
    cmd(CMD_RELEASE, '0, '0, '0, '1);

    write_reg(CFG_ALIGN_LOG2, 33'd15);
    cmd(CMD_RESERVE, 32'd1, 32'd1, 33'd1, '1);
    cmd(CMD_RESERVE, 32'd2, 32'd1, 33'd1, '1);
    write_reg(CFG_RING_SIZE, 33'd0);
    cmd(CMD_RESERVE, 32'd3, 32'd1, 33'd1, '1);

    // Random phases: idle patterns times register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        0: write_reg(CFG_RING_SIZE, 33'd65536);
        2: write_reg(CFG_RING_SIZE, 33'h1_0000_0000);
        4: write_reg(CFG_RING_SIZE, 33'd20000);
        6: write_reg(CFG_RING_SIZE, 33'd1);
        default: write_reg(CFG_RING_SIZE, 33'($urandom_range(1, 70000)));
      endcase
      write_reg(CFG_ALIGN_LOG2, (ph == 7) ? 33'd12 : 33'($urandom_range(15)));
      for (int n = 0; n < 52; n++) random_beat();
    end
    @(negedge clk);
    in_valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    $display("Run covered %0d commands, %0d result beats: %0d reserves placed, %0d exhausted.",
             sent, sb.checked, sb.n_ok, sb.n_exhausted);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
rtl/frsa_pkg.sv
rtl/fenced_ring_span_allocator_unit.sv
bench/fenced_ring_span_allocator_unit_tb.sv
